### src/dcr_pkg.sv
package dcr_pkg;

   localparam int ADDR_BITS = 48;
   localparam int MAX_RANGES_DEFAULT = 16;
   localparam int PAD_BYTES_DEFAULT = 256;

   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = ADDR_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BUFFER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CPU_BACKED = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_FRAME = 2'd2;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BOUNDS = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL = 2'd3;

   typedef struct packed {
      logic                 opcode;
      logic [ADDR_BITS-1:0] offset;
      logic [ADDR_BITS-1:0] count;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 notify_device;
      logic                 range_valid;
      logic [ADDR_BITS-1:0] range_start;
      logic [ADDR_BITS-1:0] range_end;
      logic                 last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic check;
      logic reject;
      logic full;
      logic pad;
      logic scan;
      logic finish;
      logic drain;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_drain;
      logic chk_done;
      logic chk_full;
      logic scan_done;
      logic drain_last;
   } dp_sts_type;

endpackage

### src/dcr_controller.sv
module dcr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  dcr_pkg::dp_sts_type sts,
   output dcr_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PAD,
      S_SCAN,
      S_FINISH,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_drain) begin
               state_in = S_DRAIN;
            end else begin
               cmd.check = 1'b1;
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            if (sts.chk_done) begin
               cmd.reject = 1'b1;
               state_in = S_IDLE;
            end else if (sts.chk_full) begin
               cmd.full = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.pad = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         S_DRAIN: begin
            cmd.drain = 1'b1;
            if (sts.drain_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

### src/dcr_datapath.sv
module dcr_datapath #(
   parameter int MAX_RANGES = dcr_pkg::MAX_RANGES_DEFAULT,
   parameter int PAD_BYTES = dcr_pkg::PAD_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dcr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dcr_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  dcr_pkg::req_word_type               req_word,
   input  dcr_pkg::ctl_cmd_type                cmd,
   output dcr_pkg::dp_sts_type                 sts,
   output logic                                rsp_valid,
   output dcr_pkg::rsp_word_type               rsp_word
);

   localparam int AW = dcr_pkg::ADDR_BITS;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int EW = AW + 18;
   localparam logic [EW-1:0] PAD_X = EW'(PAD_BYTES);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_RANGES);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // configuration
   logic [AW-1:0] len_ff, len_in;
   logic          cpu_backed_ff, cpu_backed_in;
   logic          first_frame_ff, first_frame_in;

   // latched request and check results
   dcr_pkg::req_word_type req_ff, req_in;
   logic [1:0]    chk_status_ff, chk_status_in;
   logic          chk_done_ff, chk_done_in;
   logic          chk_full_ff, chk_full_in;
   logic [AW-1:0] end_ff, end_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] acc_lo_ff, acc_lo_in;
   logic [AW-1:0] acc_hi_ff, acc_hi_in;
   logic [IW-1:0] slot_ff, slot_in;

   // walk control
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] proc_idx_ff, proc_idx_in;
   logic          proc_v_ff, proc_v_in;
   logic          found_ff, found_in;

   // table state
   logic [CW-1:0] count_ff, count_in;
   logic          pending_ff, pending_in;
   logic          full_copy_ff, full_copy_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   dcr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // range table
   logic [AW-1:0] start_mem [MAX_RANGES];
   logic [AW-1:0] end_mem [MAX_RANGES];
   logic [AW-1:0] rd_start_ff;
   logic [AW-1:0] rd_end_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [AW-1:0] mem_wstart;
   logic [AW-1:0] mem_wend;
   logic          mem_re;
   logic [IW-1:0] mem_raddr;

   // combinational temporaries
   logic [AW:0]   sum;
   logic          perm_ok;
   logic          oob;
   logic [EW-1:0] off_x;
   logic [EW-1:0] lo_diff;
   logic [EW-1:0] hi_sum;
   logic          issue;
   logic          match;
   logic          drain_last;

   assign drain_last = (count_ff == '0) ||
                       (proc_v_ff && (proc_idx_ff == (count_ff - ONE_C)));

   always_comb begin
      len_in = len_ff;
      cpu_backed_in = cpu_backed_ff;
      first_frame_in = first_frame_ff;
      req_in = req_ff;
      chk_status_in = chk_status_ff;
      chk_done_in = chk_done_ff;
      chk_full_in = chk_full_ff;
      end_in = end_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      acc_lo_in = acc_lo_ff;
      acc_hi_in = acc_hi_ff;
      slot_in = slot_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      proc_idx_in = proc_idx_ff;
      proc_v_in = proc_v_ff;
      found_in = found_ff;
      count_in = count_ff;
      pending_in = pending_ff;
      full_copy_in = full_copy_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in = rsp_word_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wstart = '0;
      mem_wend = '0;
      mem_re = 1'b0;
      mem_raddr = rd_ptr_ff[IW-1:0];

      sum = {1'b0, req_ff.offset} + {1'b0, req_ff.count};
      perm_ok = cpu_backed_ff ||
                (first_frame_ff && (req_ff.offset == '0) && (req_ff.count == '0));
      oob = (req_ff.offset >= len_ff) || (sum > {1'b0, len_ff});
      off_x = EW'(req_ff.offset);
      lo_diff = off_x - PAD_X;
      hi_sum = EW'(end_ff) + PAD_X;
      issue = (rd_ptr_ff < count_ff);
      match = (hi_ff >= rd_start_ff) && (lo_ff <= rd_end_ff);

      if (csr_we) begin
         unique case (csr_index)
            dcr_pkg::CSR_BUFFER_LENGTH: len_in = csr_wdata[AW-1:0];
            dcr_pkg::CSR_CPU_BACKED: cpu_backed_in = csr_wdata[0];
            dcr_pkg::CSR_FIRST_FRAME: first_frame_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         req_in = req_word;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         proc_v_in = 1'b0;
         found_in = 1'b0;
      end

      if (cmd.check) begin
         chk_status_in = !perm_ok ? dcr_pkg::ST_INVALID :
                         oob ? dcr_pkg::ST_BOUNDS : dcr_pkg::ST_OK;
         chk_done_in = !perm_ok || oob || full_copy_ff;
         chk_full_in = (req_ff.offset == '0) &&
                       ((req_ff.count == '0) || (req_ff.count == len_ff));
         end_in = (req_ff.count == '0) ? len_ff : sum[AW-1:0];
         lo_in = (off_x > PAD_X) ? lo_diff[AW-1:0] : '0;
      end

      if (cmd.reject) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = '0;
         rsp_word_in.status = chk_status_ff;
         rsp_word_in.last = 1'b1;
      end

      // whole-buffer mark: table collapses to one range
      if (cmd.full) begin
         mem_we = 1'b1;
         mem_waddr = '0;
         mem_wstart = '0;
         mem_wend = len_ff;
         count_in = ONE_C;
         full_copy_in = 1'b1;
         pending_in = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_word_in = '0;
         rsp_word_in.status = dcr_pkg::ST_OK;
         rsp_word_in.notify_device = !pending_ff;
         rsp_word_in.last = 1'b1;
      end

      if (cmd.pad) begin
         hi_in = (hi_sum > EW'(len_ff)) ? len_ff : hi_sum[AW-1:0];
         acc_lo_in = lo_ff;
         acc_hi_in = (hi_sum > EW'(len_ff)) ? len_ff : hi_sum[AW-1:0];
      end

      // compacting walk: unmatched entries slide down to wr_ptr, all matches
      // fold into the accumulator that lands in the first matched slot
      if (cmd.scan) begin
         if (issue) begin
            mem_re = 1'b1;
            rd_ptr_in = rd_ptr_ff + ONE_C;
         end
         proc_v_in = issue;
         if (proc_v_ff) begin
            if (match) begin
               if (rd_start_ff < acc_lo_ff) acc_lo_in = rd_start_ff;
               if (rd_end_ff > acc_hi_ff) acc_hi_in = rd_end_ff;
               if (!found_ff) begin
                  found_in = 1'b1;
                  slot_in = wr_ptr_ff[IW-1:0];
                  wr_ptr_in = wr_ptr_ff + ONE_C;
               end
            end else begin
               mem_we = 1'b1;
               mem_waddr = wr_ptr_ff[IW-1:0];
               mem_wstart = rd_start_ff;
               mem_wend = rd_end_ff;
               wr_ptr_in = wr_ptr_ff + ONE_C;
            end
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = '0;
         rsp_word_in.last = 1'b1;
         if (found_ff) begin
            mem_we = 1'b1;
            mem_waddr = slot_ff;
            mem_wstart = acc_lo_ff;
            mem_wend = acc_hi_ff;
            count_in = wr_ptr_ff;
            pending_in = 1'b1;
            rsp_word_in.status = dcr_pkg::ST_OK;
            rsp_word_in.notify_device = !pending_ff;
         end else if (wr_ptr_ff >= MAX_C) begin
            rsp_word_in.status = dcr_pkg::ST_TABLE_FULL;
         end else begin
            mem_we = 1'b1;
            mem_waddr = wr_ptr_ff[IW-1:0];
            mem_wstart = lo_ff;
            mem_wend = hi_ff;
            count_in = wr_ptr_ff + ONE_C;
            pending_in = 1'b1;
            rsp_word_in.status = dcr_pkg::ST_OK;
            rsp_word_in.notify_device = !pending_ff;
         end
      end

      if (cmd.drain) begin
         if (issue) begin
            mem_re = 1'b1;
            rd_ptr_in = rd_ptr_ff + ONE_C;
         end
         proc_v_in = issue;
         proc_idx_in = rd_ptr_ff;
         if (count_ff == '0) begin
            rsp_valid_in = 1'b1;
            rsp_word_in = '0;
            rsp_word_in.last = 1'b1;
         end else if (proc_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_word_in = '0;
            rsp_word_in.range_valid = 1'b1;
            rsp_word_in.range_start = rd_start_ff;
            rsp_word_in.range_end = rd_end_ff;
            rsp_word_in.last = drain_last;
         end
         if (drain_last) begin
            count_in = '0;
            pending_in = 1'b0;
            full_copy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cpu_backed_ff <= 1'b0;
         first_frame_ff <= 1'b1;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         proc_v_ff <= 1'b0;
         found_ff <= 1'b0;
         count_ff <= '0;
         pending_ff <= 1'b0;
         full_copy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         cpu_backed_ff <= cpu_backed_in;
         first_frame_ff <= first_frame_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         proc_v_ff <= proc_v_in;
         found_ff <= found_in;
         count_ff <= count_in;
         pending_ff <= pending_in;
         full_copy_ff <= full_copy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      chk_status_ff <= chk_status_in;
      chk_done_ff <= chk_done_in;
      chk_full_ff <= chk_full_in;
      end_ff <= end_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      acc_lo_ff <= acc_lo_in;
      acc_hi_ff <= acc_hi_in;
      slot_ff <= slot_in;
      proc_idx_ff <= proc_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_waddr] <= mem_wstart;
         end_mem[mem_waddr] <= mem_wend;
      end
      if (mem_re) begin
         rd_start_ff <= start_mem[mem_raddr];
         rd_end_ff <= end_mem[mem_raddr];
      end
   end

   always_comb begin
      sts.is_drain = (req_ff.opcode == dcr_pkg::OP_DRAIN);
      sts.chk_done = chk_done_ff;
      sts.chk_full = chk_full_ff;
      sts.scan_done = (rd_ptr_ff == count_ff) && !proc_v_ff;
      sts.drain_last = drain_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_C)
      else $error("range count beyond table depth");

   a_compact_behind_read: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff <= rd_ptr_ff)
      else $error("compaction write pointer overtook read pointer");

endmodule

### src/dirty_range_coalescer.sv
// Dirty range coalescer. A word is taken when start is high and busy is low;
// busy then stays high until the cycle in which the last result of that word
// is shown. Results appear on rsp_word for exactly one cycle with rsp_valid
// high and cannot be held off. A mark gives its single result after a walk
// that reads one table entry per cycle from the range memory and writes the
// compacted table back through its one write port; a rejected mark or a
// whole-buffer mark gives its result without the walk. A drain gives the N
// pending ranges of the table oldest first on consecutive cycles; with an
// empty table it gives one empty result.
// The csr_ registers may be written only while busy is low.
module dirty_range_coalescer #(
   parameter int MAX_RANGES = dcr_pkg::MAX_RANGES_DEFAULT,
   parameter int PAD_BYTES = dcr_pkg::PAD_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dcr_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   output dcr_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_we,
   input  logic [dcr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dcr_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   dcr_pkg::ctl_cmd_type cmd;
   dcr_pkg::dp_sts_type  sts;

   dcr_controller u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   dcr_datapath #(
      .MAX_RANGES (MAX_RANGES),
      .PAD_BYTES  (PAD_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   a_done_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_last_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last) |-> !busy)
      else $error("final result shown while still busy");

   a_more_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last) |-> busy)
      else $error("non-final result shown while idle");

endmodule

### tb/dirty_range_coalescer_tb.sv
`timescale 1ns / 100ps

module dirty_range_coalescer_tb;

   localparam int ADDR_BITS = dcr_pkg::ADDR_BITS;
   localparam int MAXR = dcr_pkg::MAX_RANGES_DEFAULT;
   localparam logic [ADDR_BITS-1:0] PAD = ADDR_BITS'(dcr_pkg::PAD_BYTES_DEFAULT);
   localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};
   localparam logic [dcr_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int RAND_PHASES = 7;
   localparam int PHASE_WORDS = 57;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [ADDR_BITS-1:0] len;
      bit                   cpu;
      bit                   ff;
      logic                 op;
      logic [ADDR_BITS-1:0] off;
      logic [ADDR_BITS-1:0] cnt;
      bit                   typed;
      logic [1:0]           st;
      bit                   note;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   dcr_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   dcr_pkg::rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [dcr_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [dcr_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   dirty_range_coalescer DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the range table and registers
   logic [ADDR_BITS-1:0] pend_lo [MAXR];
   logic [ADDR_BITS-1:0] pend_hi [MAXR];
   int                   pend_cnt = 0;
   bit                   pend_flag = 1'b0;
   bit                   full_flag = 1'b0;
   logic [ADDR_BITS-1:0] cfg_len = '0;
   bit                   cfg_cpu = 1'b0;
   bit                   cfg_first = 1'b1;

   dcr_pkg::rsp_word_type due_rsp[$];
   int errors = 0;
   int unsigned cycles = 0;

   plan_row_type plan [25] = '{
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_DRAIN, 48'd0, 48'd0, 1, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 1, dcr_pkg::ST_BOUNDS, 0},
      '{ROW_CSR, 48'd4096, 0, 1, dcr_pkg::OP_MARK, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd16, 48'd16, 1, dcr_pkg::ST_INVALID, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 1, dcr_pkg::ST_OK, 1},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 1, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_DRAIN, ADDR_MAX, ADDR_MAX, 0, dcr_pkg::ST_OK, 0},
      '{ROW_CSR, 48'd4096, 0, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 1, dcr_pkg::ST_INVALID, 0},
      '{ROW_CSR, 48'd4096, 1, 0, dcr_pkg::OP_MARK, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd4096, 48'd1, 1, dcr_pkg::ST_BOUNDS, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd4000, 48'd97, 1, dcr_pkg::ST_BOUNDS, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd100, 48'd10, 1, dcr_pkg::ST_OK, 1},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd1000, 48'd10, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd2000, 48'd10, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd600, 48'd100, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd4095, 48'd1, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd3000, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_DRAIN, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_CSR, ADDR_MAX, 1, 1, dcr_pkg::OP_MARK, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, ADDR_MAX - 48'd1, 48'd1, 1,
        dcr_pkg::ST_OK, 1},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, ADDR_MAX, 48'd0, 1, dcr_pkg::ST_BOUNDS, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd1, ADDR_MAX, 1, dcr_pkg::ST_BOUNDS, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_MARK, 48'd0, ADDR_MAX, 1, dcr_pkg::ST_OK, 0},
      '{ROW_WORD, 48'd0, 0, 0, dcr_pkg::OP_DRAIN, 48'd0, 48'd0, 0, dcr_pkg::ST_OK, 0}
   };

   function automatic logic [ADDR_BITS-1:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[ADDR_BITS-1:0];
   endfunction

   function automatic logic [ADDR_BITS-1:0] rand_below(input logic [ADDR_BITS-1:0] n);
      if (n == '0)
         return '0;
      return rand48() % n;
   endfunction

   // pad, clip and merge one mark into the shadow table
   function automatic logic [1:0] mark_range(input logic [ADDR_BITS-1:0] off,
                                            input logic [ADDR_BITS-1:0] cnt,
                                            output bit note);
      logic [ADDR_BITS+1:0] sum;
      logic [ADDR_BITS-1:0] c;
      logic [ADDR_BITS-1:0] lo;
      logic [ADDR_BITS-1:0] hi;
      bit push;
      bit found;
      int prev;
      int i;
      note = 1'b0;
      if (!cfg_cpu && !(cfg_first && off == '0 && cnt == '0))
         return dcr_pkg::ST_INVALID;
      sum = {2'b00, off} + {2'b00, cnt};
      if (off >= cfg_len || sum > {2'b00, cfg_len})
         return dcr_pkg::ST_BOUNDS;
      if (full_flag)
         return dcr_pkg::ST_OK;
      c = (cnt == '0) ? cfg_len - off : cnt;
      lo = (off > PAD) ? off - PAD : '0;
      sum = {2'b00, off} + {2'b00, c} + {2'b00, PAD};
      if (sum > {2'b00, cfg_len})
         sum = {2'b00, cfg_len};
      hi = sum[ADDR_BITS-1:0];
      if (c == cfg_len) begin
         pend_cnt = 0;
         full_flag = 1'b1;
         push = 1'b1;
      end else if (pend_flag) begin
         found = 1'b0;
         prev = 0;
         i = pend_cnt;
         // newest overlap takes the range, older overlaps swallow the previous one
         while (i > 0) begin
            i--;
            if (hi >= pend_lo[i] && lo <= pend_hi[i]) begin
               if (!found) begin
                  if (lo < pend_lo[i]) pend_lo[i] = lo;
                  if (hi > pend_hi[i]) pend_hi[i] = hi;
               end else begin
                  if (pend_lo[prev] < pend_lo[i]) pend_lo[i] = pend_lo[prev];
                  if (pend_hi[prev] > pend_hi[i]) pend_hi[i] = pend_hi[prev];
                  for (int j = prev; j + 1 < pend_cnt; j++) begin
                     pend_lo[j] = pend_lo[j+1];
                     pend_hi[j] = pend_hi[j+1];
                  end
                  pend_cnt--;
               end
               found = 1'b1;
               prev = i;
            end
         end
         push = !found;
      end else begin
         push = 1'b1;
      end
      if (push) begin
         if (pend_cnt >= MAXR)
            return dcr_pkg::ST_TABLE_FULL;
         pend_lo[pend_cnt] = lo;
         pend_hi[pend_cnt] = hi;
         pend_cnt++;
      end
      if (!pend_flag) begin
         pend_flag = 1'b1;
         note = 1'b1;
      end
      return dcr_pkg::ST_OK;
   endfunction

   function automatic void track_word(input dcr_pkg::req_word_type w);
      dcr_pkg::rsp_word_type r;
      bit note;
      r = '0;
      r.last = 1'b1;
      if (w.opcode == dcr_pkg::OP_MARK) begin
         r.status = mark_range(w.offset, w.count, note);
         r.notify_device = note;
         due_rsp.push_back(r);
      end else begin
         if (pend_cnt == 0) begin
            due_rsp.push_back(r);
         end else begin
            for (int k = 0; k < pend_cnt; k++) begin
               r.range_valid = 1'b1;
               r.range_start = pend_lo[k];
               r.range_end = pend_hi[k];
               r.last = (k + 1 == pend_cnt);
               due_rsp.push_back(r);
            end
         end
         pend_cnt = 0;
         pend_flag = 1'b0;
         full_flag = 1'b0;
      end
   endfunction

   task automatic drive_word(input dcr_pkg::req_word_type w);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      track_word(w);
   endtask

   // hold off until the block is idle and every word has come back
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (due_rsp.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [ADDR_BITS-1:0] len, input bit cpu, input bit ff);
      logic [ADDR_BITS-1:0] junk;
      settle();
      csr_we <= 1'b1;
      csr_index <= dcr_pkg::CSR_BUFFER_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      cfg_len = len;
      junk = rand48();
      csr_index <= dcr_pkg::CSR_CPU_BACKED;
      csr_wdata <= {junk[ADDR_BITS-2:0], cpu};
      @(posedge clock);
      cfg_cpu = cpu;
      junk = rand48();
      csr_index <= dcr_pkg::CSR_FIRST_FRAME;
      csr_wdata <= {junk[ADDR_BITS-2:0], ff};
      @(posedge clock);
      cfg_first = ff;
      // unused index, must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= rand48();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : check_rsp
      dcr_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (due_rsp.size() == 0) begin
            $error("unexpected word: status %0d range %0h..%0h", rsp_word.status,
                   rsp_word.range_start, rsp_word.range_end);
            errors++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.notify_device !== want.notify_device) begin
               $error("notify_device: expected %0d, got %0d", want.notify_device,
                      rsp_word.notify_device);
               errors++;
            end
            if (rsp_word.range_valid !== want.range_valid) begin
               $error("range_valid: expected %0d, got %0d", want.range_valid,
                      rsp_word.range_valid);
               errors++;
            end
            if (rsp_word.range_start !== want.range_start) begin
               $error("range_start: expected %0h, got %0h", want.range_start,
                      rsp_word.range_start);
               errors++;
            end
            if (rsp_word.range_end !== want.range_end) begin
               $error("range_end: expected %0h, got %0h", want.range_end, rsp_word.range_end);
               errors++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_word.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      dcr_pkg::req_word_type w;
      dcr_pkg::rsp_word_type r;
      logic [ADDR_BITS-1:0] len;
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] span;
      int pick;
      bit quiet;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            set_config(plan[i].len, plan[i].cpu, plan[i].ff);
         end else begin
            w.opcode = plan[i].op;
            w.offset = plan[i].off;
            w.count = plan[i].cnt;
            drive_word(w);
            if (plan[i].typed) begin
               r = due_rsp.pop_back();
               r.status = plan[i].st;
               r.notify_device = plan[i].note;
               due_rsp.push_back(r);
            end
         end
      end

      // seventeen disjoint marks: the last finds the table full
      set_config(ADDR_MAX, 1'b1, 1'b0);
      for (int k = 0; k <= MAXR; k++) begin
         w.opcode = dcr_pkg::OP_MARK;
         w.offset = (ADDR_BITS'(k) << 20) + ADDR_BITS'($urandom_range(4000));
         w.count = ADDR_BITS'($urandom_range(1, 2000));
         drive_word(w);
      end
      w.opcode = dcr_pkg::OP_DRAIN;
      drive_word(w);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         quiet = (ph == RAND_PHASES - 1);
         case ($urandom_range(4))
            0: len = ADDR_BITS'($urandom_range(1, 3000));
            1: len = 48'd65536;
            2: len = rand48() | 48'd1;
            3: len = ADDR_MAX;
            default: len = ADDR_BITS'($urandom_range(300, 1024));
         endcase
         set_config(len, $urandom_range(9) != 0, $urandom_range(1) != 0);
         // keep marks in a narrow window so they overlap and merge
         base = (len > 48'd20000) ? rand_below(len - 48'd20000) : '0;
         span = (len > 48'd20000) ? 48'd20000 : len;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = $urandom_range(99);
            w.opcode = dcr_pkg::OP_MARK;
            w.offset = base + rand_below(span);
            w.count = ADDR_BITS'($urandom_range(600));
            if (pick < 8) begin
               w.opcode = dcr_pkg::OP_DRAIN;
               w.offset = rand48();
               w.count = rand48();
            end else if (pick < 12) begin
               w.offset = rand48();
               w.count = rand48();
            end else if (pick < 15) begin
               w.offset = '0;
               w.count = ($urandom_range(1) != 0) ? len : '0;
            end else if (pick < 19) begin
               w.count = '0;
            end else if (pick < 27) begin
               w.count = rand_below(len - w.offset + 48'd1);
            end
            if (!quiet && $urandom_range(99) < 2) begin
               settle();
            end else if (!quiet && $urandom_range(2) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            drive_word(w);
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (due_rsp.size() != 0 || busy);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
